// ===== rtl/bwb_pkg.sv =====
`default_nettype none

package bwb_pkg;

  // Candidates: four slots from each endpoint, interleaved a0,b0,a1,b1,...
  localparam int unsigned NumCand  = 8;
  localparam int unsigned NumSlot  = 4;
  // Only the first three kept slots are divided; the last takes the remainder.
  localparam int unsigned NumDiv   = 3;
  localparam int unsigned BoneW    = 8;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned FieldW   = 32;
  // Merged weight: up to 8 * 255 = 2040.
  localparam int unsigned WtW      = 11;
  // Kept total: up to 4 * 2040 = 8160.
  localparam int unsigned TotW     = 13;
  // Divisor 2 * total.
  localparam int unsigned DenW     = TotW + 1;
  // Dividend 510 * w + total stays below 2^20; den << 7 needs 21 bits.
  localparam int unsigned RemW     = 21;
  localparam int unsigned QuoW     = 8;
  localparam int unsigned CntW     = 4;
  localparam int unsigned PosW     = 3;
  localparam int unsigned KeepW    = 3;
  localparam int unsigned AccW     = 10;
  localparam int unsigned DivBitsPerStage = 2;
  localparam int unsigned NumDivStages    = QuoW / DivBitsPerStage;

  localparam int unsigned InW  = 4 * FieldW;
  localparam int unsigned OutW = 2 * FieldW;

  localparam logic [ByteW-1:0] FullWeight = 8'd255;

  typedef struct packed {
    logic [BoneW-1:0] bone;
    logic [WtW-1:0]   wt;
  } entry_t;

  typedef entry_t [NumCand-1:0] list_t;

  // Merged list travelling through the selection stages.
  typedef struct packed {
    list_t            list;
    logic [CntW-1:0]  count;
    logic [BoneW-1:0] a0;
  } sel_t;

  // Renormalization state travelling through the divider stages.
  typedef struct packed {
    logic [KeepW-1:0]                  keep;
    logic [NumSlot-1:0][BoneW-1:0]     bone;
    logic [BoneW-1:0]                  a0;
    logic [DenW-1:0]                   den;
    logic [NumDiv-1:0][RemW-1:0]       rem;
    logic [NumDiv-1:0][QuoW-1:0]       quo;
  } norm_t;

  // Position of the first strictly largest weight at or after lo.
  // Registered-free tree; ties keep the lower position.
  function automatic logic [PosW-1:0] first_max(input list_t l, input logic [PosW-1:0] lo);
    logic [NumCand-1:0]           ok;
    logic [NumCand-1:0][WtW-1:0]  w;
    logic [NumCand-1:0][PosW-1:0] ix;
    logic                         take_r;
    for (int p = 0; p < NumCand; p++) begin
      ok[p] = (PosW'(p) >= lo);
      w[p]  = l[p].wt;
      ix[p] = PosW'(p);
    end
    for (int lvl = 0; lvl < PosW; lvl++) begin
      for (int p = 0; p < NumCand / 2; p++) begin
        if (p < (NumCand >> (lvl + 1))) begin
          take_r = ok[2*p+1] && (!ok[2*p] || (w[2*p+1] > w[2*p]));
          ok[p]  = ok[2*p] || ok[2*p+1];
          w[p]   = take_r ? w[2*p+1]  : w[2*p];
          ix[p]  = take_r ? ix[2*p+1] : ix[2*p];
        end
      end
    end
    return ix[0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bone_weight_blend_top4.sv =====
`default_nettype none

// Skinning weight merge: each request carries two vertices' four bone
// influences; the block merges equal bones, keeps the four heaviest (selection
// order, ties to the earlier entry) and rescales them to sum to 255, rounding
// half up, with the last kept slot taking the remainder (floored at zero).
// With no nonzero weight the result is A's first bone at 255. Throughput is
// one request per clock while the output is not stalled; from input accept to
// output valid it passes 2 merge stages, 4 selection stages (one per kept
// slot), 1 prep stage, 4 divider stages (the 8-bit quotient resolved two
// bits per stage) and the output register. Every stage holds while the next
// is full, so backpressure on the output side loses and repeats nothing, and
// empty stages keep filling while a result waits.
module bone_weight_blend_top4 (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // first_indices, first_weights, second_indices, second_weights (low to high)
  input  wire logic [bwb_pkg::InW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // blended_indices, blended_weights (low to high)
  output logic [bwb_pkg::OutW-1:0]      m_axis_tdata
);
  import bwb_pkg::*;

  logic merge_valid, merge_ready;
  sel_t merge_data;

  logic [NumSlot:0] sel_valid;
  logic [NumSlot:0] sel_ready;
  sel_t             sel_data [NumSlot+1];

  // Merge and compaction.
  bwb_merge u_merge (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .first_indices_i  (s_axis_tdata[0*FieldW +: FieldW]),
    .first_weights_i  (s_axis_tdata[1*FieldW +: FieldW]),
    .second_indices_i (s_axis_tdata[2*FieldW +: FieldW]),
    .second_weights_i (s_axis_tdata[3*FieldW +: FieldW]),
    .out_valid_o      (merge_valid),
    .out_ready_i      (merge_ready),
    .out_data_o       (merge_data)
  );

  assign sel_valid[0] = merge_valid;
  assign merge_ready  = sel_ready[0];
  assign sel_data[0]  = merge_data;

  // One selection step per kept slot.
  for (genvar i = 0; i < NumSlot; i++) begin : g_sel
    bwb_select #(
      .SlotIdx (i)
    ) u_select (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (sel_valid[i]),
      .in_ready_o  (sel_ready[i]),
      .in_data_i   (sel_data[i]),
      .out_valid_o (sel_valid[i+1]),
      .out_ready_i (sel_ready[i+1]),
      .out_data_o  (sel_data[i+1])
    );
  end

  // Rescale to 255 and drive the output register.
  bwb_norm u_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sel_valid[NumSlot]),
    .in_ready_o  (sel_ready[NumSlot]),
    .in_data_i   (sel_data[NumSlot]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== rtl/bwb_merge.sv =====
`default_nettype none

// Two stages: duplicate detection and per-bone sums, then compaction.
module bwb_merge (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [bwb_pkg::FieldW-1:0]    first_indices_i,
  input  wire logic [bwb_pkg::FieldW-1:0]    first_weights_i,
  input  wire logic [bwb_pkg::FieldW-1:0]    second_indices_i,
  input  wire logic [bwb_pkg::FieldW-1:0]    second_weights_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output bwb_pkg::sel_t                      out_data_o
);
  import bwb_pkg::*;

  logic [1:0] v_q;
  logic       rdy0, rdy1;

  logic [NumCand-1:0][BoneW-1:0] cand_bone;
  logic [NumCand-1:0][ByteW-1:0] cand_wt;
  logic [NumCand-1:0]            first_d;
  logic [NumCand-1:0][WtW-1:0]   sum_d;

  logic [NumCand-1:0]            first_q;
  logic [NumCand-1:0][BoneW-1:0] bone_q;
  logic [NumCand-1:0][WtW-1:0]   sum_q;
  logic [BoneW-1:0]              a0_q;

  sel_t sel_d, sel_q;

  assign rdy1       = !v_q[1] || out_ready_i;
  assign rdy0       = !v_q[0] || rdy1;
  assign in_ready_o = rdy0;

  // Stage 1: first occurrence flags and summed weights per bone.
  always_comb begin
    logic dup;
    for (int j = 0; j < NumCand; j++) begin
      if (j % 2 == 0) begin
        cand_bone[j] = first_indices_i[ByteW*(j>>1) +: ByteW];
        cand_wt[j]   = first_weights_i[ByteW*(j>>1) +: ByteW];
      end else begin
        cand_bone[j] = second_indices_i[ByteW*(j>>1) +: ByteW];
        cand_wt[j]   = second_weights_i[ByteW*(j>>1) +: ByteW];
      end
    end
    for (int j = 0; j < NumCand; j++) begin
      dup      = 1'b0;
      sum_d[j] = '0;
      for (int k = 0; k < NumCand; k++) begin
        if (k < j && cand_wt[k] != '0 && cand_bone[k] == cand_bone[j]) dup = 1'b1;
        if (k >= j && cand_bone[k] == cand_bone[j]) sum_d[j] = sum_d[j] + WtW'(cand_wt[k]);
      end
      first_d[j] = (cand_wt[j] != '0) && !dup;
    end
  end

  // Stage 2: pack first occurrences to the front, in order.
  always_comb begin
    logic [PosW-1:0] rank;
    logic [CntW-1:0] cnt;
    sel_d      = '0;
    sel_d.a0   = a0_q;
    rank       = '0;
    cnt        = '0;
    for (int j = 0; j < NumCand; j++) begin
      if (first_q[j]) begin
        sel_d.list[rank].bone = bone_q[j];
        sel_d.list[rank].wt   = sum_q[j];
        rank = rank + PosW'(1);
        cnt  = cnt + CntW'(1);
      end
    end
    sel_d.count = cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy0) v_q[0] <= in_valid_i;
      if (rdy1) v_q[1] <= v_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && in_valid_i) begin
      first_q <= first_d;
      bone_q  <= cand_bone;
      sum_q   <= sum_d;
      a0_q    <= first_indices_i[ByteW-1:0];
    end
    if (rdy1 && v_q[0]) begin
      sel_q <= sel_d;
    end
  end

  assign out_valid_o = v_q[1];
  assign out_data_o  = sel_q;

endmodule

`default_nettype wire

// ===== rtl/bwb_select.sv =====
`default_nettype none

// One selection step: slot SlotIdx swaps with the first largest entry at or after it.
module bwb_select #(
  parameter int unsigned SlotIdx = 0
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire bwb_pkg::sel_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output bwb_pkg::sel_t out_data_o
);
  import bwb_pkg::*;

  logic            v_q;
  logic [PosW-1:0] best;
  sel_t            swap_d, swap_q;

  assign in_ready_o = !v_q || out_ready_i;

  // Empty entries carry weight zero, so they never win over a live one.
  always_comb begin
    best   = first_max(in_data_i.list, PosW'(SlotIdx));
    swap_d = in_data_i;
    swap_d.list[best]    = in_data_i.list[SlotIdx];
    swap_d.list[SlotIdx] = in_data_i.list[best];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) swap_q <= swap_d;
  end

  assign out_valid_o = v_q;
  assign out_data_o  = swap_q;

endmodule

`default_nettype wire

// ===== rtl/bwb_norm.sv =====
`default_nettype none

// Renormalization: total and dividends, radix-2 restoring divide at two
// quotient bits per stage, then remainder slot and output packing.
module bwb_norm (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire bwb_pkg::sel_t            in_data_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [bwb_pkg::OutW-1:0]      out_data_o
);
  import bwb_pkg::*;

  localparam int unsigned NumStg = NumDivStages + 2;

  logic [NumStg-1:0] v_q;
  logic [NumStg:0]   rdy;
  logic [NumStg-1:0] v_in;

  norm_t            norm_d [NumDivStages+1];
  norm_t            norm_q [NumDivStages+1];
  logic [OutW-1:0]  out_d, out_q;

  always_comb begin
    rdy[NumStg] = out_ready_i;
    for (int k = NumStg - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    for (int k = 0; k < NumStg; k++) begin
      v_in[k] = (k == 0) ? in_valid_i : v_q[(k == 0) ? 0 : k - 1];
    end
  end

  assign in_ready_o = rdy[0];

  // Prep: keep count, kept total, dividend 510 * w + total per divided slot.
  always_comb begin
    logic [TotW-1:0] total;
    logic [RemW-1:0] wx;
    norm_d[0]      = '0;
    norm_d[0].a0   = in_data_i.a0;
    norm_d[0].keep = (in_data_i.count > CntW'(NumSlot)) ? KeepW'(NumSlot)
                                                         : KeepW'(in_data_i.count);
    total = '0;
    for (int i = 0; i < NumSlot; i++) begin
      total = total + TotW'(in_data_i.list[i].wt);
      norm_d[0].bone[i] = in_data_i.list[i].bone;
    end
    norm_d[0].den = {total, 1'b0};
    for (int i = 0; i < NumDiv; i++) begin
      wx = RemW'(in_data_i.list[i].wt);
      norm_d[0].rem[i] = (wx << 9) - (wx << 1) + RemW'(total);
    end
  end

  for (genvar s = 0; s < NumDivStages; s++) begin : g_div
    always_comb begin
      logic [RemW-1:0] sub_v;
      norm_d[s+1] = norm_q[s];
      for (int i = 0; i < NumDiv; i++) begin
        for (int b = 0; b < DivBitsPerStage; b++) begin
          sub_v = RemW'(norm_q[s].den) << (QuoW - 1 - (s * DivBitsPerStage + b));
          if (norm_d[s+1].rem[i] >= sub_v) begin
            norm_d[s+1].rem[i] = norm_d[s+1].rem[i] - sub_v;
            norm_d[s+1].quo[i][QuoW - 1 - (s * DivBitsPerStage + b)] = 1'b1;
          end
        end
      end
    end
  end

  // Pack: last kept slot gets 255 minus the earlier ones, floored at zero; with none kept, a0 at 255.
  always_comb begin
    logic [AccW-1:0]  acc;
    logic [ByteW-1:0] last;
    norm_t            n;
    n   = norm_q[NumDivStages];
    acc = '0;
    for (int i = 0; i < NumDiv; i++) begin
      if (KeepW'(i + 1) < n.keep) acc = acc + AccW'(n.quo[i]);
    end
    last  = (acc > AccW'(FullWeight)) ? '0 : ByteW'(AccW'(FullWeight) - acc);
    out_d = '0;
    if (n.keep == '0) begin
      out_d[ByteW-1:0]               = n.a0;
      out_d[FieldW +: ByteW]         = FullWeight;
    end else begin
      for (int i = 0; i < NumSlot; i++) begin
        if (KeepW'(i) < n.keep) out_d[ByteW*i +: ByteW] = n.bone[i];
        if (KeepW'(i + 1) == n.keep) begin
          out_d[FieldW + ByteW*i +: ByteW] = last;
        end else if (KeepW'(i + 1) < n.keep && i < NumDiv) begin
          out_d[FieldW + ByteW*i +: ByteW] = n.quo[(i < NumDiv) ? i : 0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NumStg; k++) begin
        if (rdy[k]) v_q[k] <= v_in[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= NumDivStages; k++) begin
      if (rdy[k] && v_in[k]) norm_q[k] <= norm_d[k];
    end
    if (rdy[NumStg-1] && v_in[NumStg-1]) out_q <= out_d;
  end

  assign out_valid_o = v_q[NumStg-1];
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/bwb_checker.sv =====
`default_nettype none

module bwb_checker (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     s_axis_tvalid,
  input wire logic                     s_axis_tready,
  input wire logic                     m_axis_tvalid,
  input wire logic                     m_axis_tready,
  input wire logic [bwb_pkg::OutW-1:0] m_axis_tdata
);
  import bwb_pkg::*;

  localparam int unsigned PipeDepth = 12;

  logic [CntW-1:0] inflight_q;
  logic            in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_acc && !out_acc) begin
      inflight_q <= inflight_q + CntW'(1);
    end else if (out_acc && !in_acc) begin
      inflight_q <= inflight_q - CntW'(1);
    end
  end

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");

  // No result without an outstanding request, never more than the pipe holds.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> inflight_q != '0)
    else $error("result without request");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CntW'(PipeDepth))
    else $error("more requests in flight than stages");

  // Heaviest slot is never empty and never lighter than the second.
  a_lead_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[FieldW +: ByteW] != '0)
    else $error("leading weight is zero");

  a_lead_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[FieldW +: ByteW] >= m_axis_tdata[FieldW + ByteW +: ByteW])
    else $error("weights out of order");

endmodule

bind bone_weight_blend_top4 bwb_checker u_bwb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/bone_weight_blend_top4_test.sv =====
`default_nettype none

module bone_weight_blend_top4_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bwb_pkg::*;

  // Run limit in clock cycles.
  localparam int unsigned CycleLimit = 200_000;
  // Extra cycles after the last result.
  localparam int unsigned DrainWait  = 40;
  // Idle phases change after these many accepted requests.
  localparam int unsigned PhaseOneEnd = 520;
  localparam int unsigned PhaseTwoEnd = 1040;
  // Long output stall: starts once this many requests are in; HoldCycles sets its length.
  localparam int unsigned HoldStart  = 1150;
  localparam int unsigned HoldCycles = 250;
  localparam int unsigned NumRandom  = 1530;

  // One vertex pair; the four words go out as tdata, first_indices lowest.
  typedef struct {
    logic [FieldW-1:0] a_idx;
    logic [FieldW-1:0] a_wt;
    logic [FieldW-1:0] b_idx;
    logic [FieldW-1:0] b_wt;
    bit                drain;  // hold this request until no result is pending
  } vertex_req_t;

  logic            clk_i;
  logic            rst_ni;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  // first_indices, first_weights, second_indices, second_weights (low to high)
  logic [InW-1:0]  s_axis_tdata;
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  // blended_indices, blended_weights (low to high)
  logic [OutW-1:0] m_axis_tdata;

  vertex_req_t     pending_q[$];   // requests not yet put on the bus
  logic [OutW-1:0] blend_q[$];     // predicted results, oldest first
  int unsigned     accepted_n;
  int unsigned     total_n;
  int unsigned     mismatch_n;
  int unsigned     cycle_n;
  int unsigned     hold_left;
  bit              hold_done;
  bit              req_taken;      // request accepted at the last rising edge

  bone_weight_blend_top4 DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Blend prediction: merge in a0,b0,a1,b1,... order, skip zero weights,
  // sum equal bones, selection-sort the first four slots (first strictly
  // largest wins), then rescale to 255 with round half up. The last kept
  // slot takes the remainder, floored at zero.
  function automatic logic [OutW-1:0] blend_expect(input logic [InW-1:0] req);
    logic [BoneW-1:0] bone [NumCand];
    logic [WtW-1:0]   wt   [NumCand];
    logic [BoneW-1:0] cand_bone;
    logic [ByteW-1:0] cand_wt;
    logic [BoneW-1:0] tmp_bone;
    logic [WtW-1:0]   tmp_wt;
    logic [FieldW-1:0] idx_out;
    logic [FieldW-1:0] wt_out;
    int unsigned n, keep, best, total, acc, share, base;
    bit          found;
    n = 0;
    idx_out = '0;
    wt_out = '0;
    for (int s = 0; s < NumCand; s++) begin
      // even s from endpoint A, odd from endpoint B; slot s/2
      base = (s % 2) * 2 * FieldW;
      cand_bone = req[base + (s / 2) * ByteW +: ByteW];
      cand_wt   = req[base + FieldW + (s / 2) * ByteW +: ByteW];
      if (cand_wt != 0) begin
        found = 1'b0;
        for (int i = 0; i < n; i++) begin
          if (!found && bone[i] == cand_bone) begin
            wt[i] = wt[i] + cand_wt;
            found = 1'b1;
          end
        end
        if (!found) begin
          bone[n] = cand_bone;
          wt[n]   = WtW'(cand_wt);
          n++;
        end
      end
    end
    for (int i = 0; i < NumSlot && i < n; i++) begin
      best = i;
      for (int j = i + 1; j < n; j++)
        if (wt[j] > wt[best]) best = j;
      tmp_wt = wt[i];     wt[i] = wt[best];     wt[best] = tmp_wt;
      tmp_bone = bone[i]; bone[i] = bone[best]; bone[best] = tmp_bone;
    end
    keep = (n < NumSlot) ? n : NumSlot;
    total = 0;
    for (int i = 0; i < keep; i++) total += wt[i];
    // nothing weighted: A's first bone at full weight
    if (total == 0) return {FieldW'(FullWeight), 24'd0, req[BoneW-1:0]};
    acc = 0;
    for (int i = 0; i < keep; i++) begin
      if (i == keep - 1)
        share = (acc > FullWeight) ? 0 : FullWeight - acc;
      else
        share = (2 * wt[i] * FullWeight + total) / (2 * total);
      acc += share;
      idx_out[ByteW*i +: ByteW] = bone[i];
      wt_out[ByteW*i +: ByteW]  = share[ByteW-1:0];
    end
    return {wt_out, idx_out};
  endfunction

  task automatic report_mismatch(input string what, input logic [FieldW-1:0] got,
                                 input logic [FieldW-1:0] want);
    $display("%0t ns: %s got %08h expected %08h", $time, what, got, want);
    mismatch_n++;
  endtask

  task automatic add_request(input logic [FieldW-1:0] a_idx, input logic [FieldW-1:0] a_wt,
                             input logic [FieldW-1:0] b_idx, input logic [FieldW-1:0] b_wt);
    vertex_req_t r;
    r.a_idx = a_idx;
    r.a_wt  = a_wt;
    r.b_idx = b_idx;
    r.b_wt  = b_wt;
    r.drain = 1'b0;
    pending_q = {pending_q, r};
  endtask

  // Weight byte by flavor: mostly nonzero, sparse, or skewed toward
  // values that push the rounding and the remainder clamp.
  function automatic logic [ByteW-1:0] pick_weight(input int unsigned mode);
    case (mode)
      7:       return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      8:       return ($urandom_range(0, 7) != 0) ? 8'd0 : 8'($urandom_range(1, 255));
      9: begin
        case ($urandom_range(0, 3))
          0:       return 8'd1;
          1:       return 8'd2;
          2:       return 8'd255;
          default: return 8'($urandom_range(120, 136));
        endcase
      end
      default: return ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    endcase
  endfunction

  // Random vertex pair. Most draw bones from a narrow window so that bones
  // repeat and merge; a fifth are raw noise across all bits.
  task automatic add_random(input bit drain);
    vertex_req_t r;
    int unsigned mode, base, spread;
    r.drain = drain;
    r.a_idx = $urandom();
    r.a_wt  = $urandom();
    r.b_idx = $urandom();
    r.b_wt  = $urandom();
    mode = $urandom_range(0, 9);
    if (mode >= 2) begin
      base   = $urandom_range(0, 255);
      spread = (mode == 7) ? 2 : 5;
      for (int k = 0; k < NumSlot; k++) begin
        r.a_idx[ByteW*k +: ByteW] = 8'(base + $urandom_range(0, spread));
        r.b_idx[ByteW*k +: ByteW] = 8'(base + $urandom_range(0, spread));
        r.a_wt[ByteW*k +: ByteW]  = pick_weight(mode);
        r.b_wt[ByteW*k +: ByteW]  = pick_weight(mode);
      end
    end
    pending_q = {pending_q, r};
  endtask

  // Cycle limit: a hung block or a lost result ends here.
  always @(posedge clk_i) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n == CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Request driver: changes on the falling edge. A request stays on the bus
  // until accepted; a new one goes out only after the previous was taken.
  // Sender idling: 6 percent first, then 46, then none.
  always @(negedge clk_i) begin
    if (rst_ni && (req_taken || !s_axis_tvalid)) begin
      if (pending_q.size() != 0 &&
          !(pending_q[0].drain && blend_q.size() != 0) &&
          $urandom_range(0, 99) >= ((accepted_n < PhaseOneEnd) ? 6 :
                                    (accepted_n < PhaseTwoEnd) ? 46 : 0)) begin
        s_axis_tdata  <= {pending_q[0].b_wt, pending_q[0].b_idx,
                          pending_q[0].a_wt, pending_q[0].a_idx};
        s_axis_tvalid <= 1'b1;
        void'(pending_q.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: 46 percent stalls first, then 6, then none, with one
  // long hold-off late in the run so the pipeline fills and blocks input.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && accepted_n >= HoldStart) begin
        hold_done     <= 1'b1;
        hold_left     <= HoldCycles;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= $urandom_range(0, 99) >= ((accepted_n < PhaseOneEnd) ? 46 :
                                                   (accepted_n < PhaseTwoEnd) ? 6 : 0);
      end
    end
  end

  // Monitor on the rising edge: check the result first, then record the
  // request so a result in the same edge cannot match its own request.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (blend_q.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata[FieldW-1:0],
                          m_axis_tdata[OutW-1:FieldW]);
        end else begin
          if (m_axis_tdata[FieldW-1:0] !== blend_q[0][FieldW-1:0])
            report_mismatch("blended_indices", m_axis_tdata[FieldW-1:0],
                            blend_q[0][FieldW-1:0]);
          if (m_axis_tdata[OutW-1:FieldW] !== blend_q[0][OutW-1:FieldW])
            report_mismatch("blended_weights", m_axis_tdata[OutW-1:FieldW],
                            blend_q[0][OutW-1:FieldW]);
          void'(blend_q.pop_front());
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        blend_q = {blend_q, blend_expect(s_axis_tdata)};
        accepted_n++;
      end
      req_taken <= s_axis_tvalid && s_axis_tready;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    accepted_n    = 0;
    mismatch_n    = 0;
    cycle_n       = 0;
    hold_left     = 0;
    hold_done     = 1'b0;
    req_taken     = 1'b0;

    // Directed requests.
    // no weight at all: result is A's first bone at 255
    add_request(32'hDEADBE7F, 32'h0, 32'h12345678, 32'h0);
    add_request(32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h0);
    // one weight only, in A slot 0 and in B slot 3
    add_request(32'h00000000, 32'h000000FF, 32'h11111111, 32'h0);
    add_request(32'h01020304, 32'h0, 32'hFF000000, 32'h01000000);
    // one bone everywhere at full weight: merged weight 2040
    add_request(32'h00000000, 32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF);
    add_request(32'h77777777, 32'hFFFFFFFF, 32'h77777777, 32'hFFFFFFFF);
    // eight distinct bones, all tied: first four in visit order survive
    add_request(32'h07050301, 32'hFFFFFFFF, 32'h08060402, 32'hFFFFFFFF);
    // eight distinct bones, weights rising: the last four survive
    add_request(32'h07050301, 32'h70503010, 32'h08060402, 32'h80604020);
    // same bones in the same order on both sides
    add_request(32'h04030201, 32'h40302010, 32'h04030201, 32'h05060708);
    // B repeats A's bones in reverse order
    add_request(32'h0D0C0B0A, 32'h01020304, 32'h0A0B0C0D, 32'hC8643219);
    // fewer than four bones: unused bytes stay zero
    add_request(32'h00002A2A, 32'h00006432, 32'h00000015, 32'h000000C8);
    add_request(32'h00030201, 32'h00556677, 32'h00000000, 32'h00000000);
    // ties with a later larger weight
    add_request(32'h04030201, 32'h05141409, 32'h01020304, 32'h000A0B00);
    // weight on B only
    add_request(32'h99999999, 32'h00000000, 32'hF0E0D0C0, 32'h11223344);
    // three heavy bones and a light fourth: remainder clamps toward zero
    add_request(32'h04030201, 32'h01FFFFFF, 32'h00000000, 32'h00000000);
    add_request(32'h04030201, 32'h01FEFFFF, 32'h08070605, 32'h01010101);
    add_request(32'h04030201, 32'h0101AA55, 32'h04030201, 32'h01018080);
    // bit pattern extremes
    add_request(32'hAAAAAAAA, 32'h55AA55AA, 32'h55555555, 32'hAA55AA55);
    add_request(32'hFFFFFFFF, 32'h01010101, 32'h00000000, 32'h01010101);
    add_request(32'h80402010, 32'h80808080, 32'h01020408, 32'h7F7F7F7F);

    // Random requests; two of them wait until every result is back.
    for (int k = 0; k < NumRandom; k++)
      add_random(k == 40 || k == 600);
    total_n = pending_q.size();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_n != total_n) @(negedge clk_i);
    while (blend_q.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);

    if (mismatch_n == 0 && blend_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/bwb_pkg.sv
rtl/bwb_merge.sv
rtl/bwb_select.sv
rtl/bwb_norm.sv
rtl/bone_weight_blend_top4.sv
rtl/bwb_checker.sv
tb/bone_weight_blend_top4_test.sv
